// ----- src/assert_macros.svh -----
// Assertion macros included by rational_number_alu.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked every clock edge outside reset.
`define RNA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Condition that must never hold outside reset.
`define RNA_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define RNA_ASSERT(label, clk, rst_n, prop)
`define RNA_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- src/rna_pkg.sv -----
// Types and codes of the rational number ALU.
package rna_pkg;

  // Operation codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  // Shared unit operations
  typedef enum logic [1:0] {
    U_GCD,
    U_DIV64,
    U_DIV128,
    U_MUL
  } unit_op_t;

  typedef struct packed {
    logic         start;
    unit_op_t     kind;
    logic [127:0] x;
    logic [63:0]  y;
  } unit_cmd_t;

  typedef struct packed {
    logic         busy;
    logic         done;
    logic [127:0] res;
    logic [63:0]  rem;
  } unit_rsp_t;

  // Sequencer states
  typedef enum logic [5:0] {
    S_IDLE, S_CHK,
    S_NA_G, S_NA_N, S_NA_D,
    S_NB_G, S_NB_N, S_NB_D,
    S_DISP,
    S_AD_G, S_AD_D1, S_AD_D2, S_AD_P, S_AD_Q, S_AD_T,
    S_AD_R, S_AD_G2, S_AD_T2, S_AD_D3, S_AD_M,
    S_MU_G1, S_MU_G2, S_MU_AN, S_MU_BD, S_MU_BN, S_MU_AD, S_MU_M1, S_MU_M2,
    S_CM_L, S_CM_R, S_CM_C,
    S_EMIT, S_FIN
  } state_t;

endpackage

// ----- src/rna_if.sv -----
// Handshake channels of the rational number ALU.
interface rna_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [63:0] a_num;
  logic signed [63:0] a_den;
  logic signed [63:0] b_num;
  logic signed [63:0] b_den;
  modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rna_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] res_num;
  logic [62:0]        res_den;
  logic [1:0]         status;
  logic               less;
  logic               equal;
  modport source (output valid, res_num, res_den, status, less, equal, input ready);
  modport sink   (input valid, res_num, res_den, status, less, equal, output ready);
endinterface

// ----- src/rna_unit.sv -----
// Shared arithmetic unit: binary gcd, bit-serial divider, 4-step multiplier.
module rna_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  rna_pkg::unit_cmd_t cmd,
  output rna_pkg::unit_rsp_t rsp
);
  import rna_pkg::*;

  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  unit_op_t     kind_r, kind_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [63:0]  aux_r, aux_nxt;
  logic [63:0]  y_r, y_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic [5:0]   k_r, k_nxt;

  logic [64:0]  rsh;
  logic [64:0]  diff;
  logic         ge;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [6:0]   sh;

  // Divider step
  assign rsh  = {aux_r, acc_r[127]};
  assign diff = rsh - {1'b0, y_r};
  assign ge   = rsh >= {1'b0, y_r};

  // Partial product select
  always_comb begin
    case (cnt_r[1:0])
      2'd3:    begin pa = aux_r[31:0];  pb = y_r[31:0];  sh = 7'd0;  end
      2'd2:    begin pa = aux_r[31:0];  pb = y_r[63:32]; sh = 7'd32; end
      2'd1:    begin pa = aux_r[63:32]; pb = y_r[31:0];  sh = 7'd32; end
      default: begin pa = aux_r[63:32]; pb = y_r[63:32]; sh = 7'd64; end
    endcase
  end
  assign pp = pa * pb;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    kind_nxt = kind_r;
    acc_nxt  = acc_r;
    aux_nxt  = aux_r;
    y_nxt    = y_r;
    cnt_nxt  = cnt_r;
    k_nxt    = k_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      kind_nxt = cmd.kind;
      y_nxt    = cmd.y;
      k_nxt    = '0;
      unique case (cmd.kind)
        U_DIV64: begin
          acc_nxt = {cmd.x[63:0], 64'd0};
          aux_nxt = '0;
          cnt_nxt = 7'd63;
        end
        U_DIV128: begin
          acc_nxt = cmd.x;
          aux_nxt = '0;
          cnt_nxt = 7'd127;
        end
        U_MUL: begin
          acc_nxt = '0;
          aux_nxt = cmd.x[63:0];
          cnt_nxt = 7'd3;
        end
        default: begin
          aux_nxt = cmd.x[63:0];
        end
      endcase
    end else if (busy_r) begin
      unique case (kind_r)
        U_DIV64, U_DIV128: begin
          aux_nxt = ge ? diff[63:0] : rsh[63:0];
          acc_nxt = {acc_r[126:0], ge};
          cnt_nxt = cnt_r - 7'd1;
          if (cnt_r == '0) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        U_MUL: begin
          acc_nxt = acc_r + ({64'd0, pp} << sh);
          cnt_nxt = cnt_r - 7'd1;
          if (cnt_r[1:0] == 2'd0) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        default: begin
          // binary gcd, one step a cycle
          if (aux_r == '0) begin
            acc_nxt  = {64'd0, y_r << k_r};
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end else if (y_r == '0) begin
            acc_nxt  = {64'd0, aux_r << k_r};
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end else if (!aux_r[0] && !y_r[0]) begin
            aux_nxt = aux_r >> 1;
            y_nxt   = y_r >> 1;
            k_nxt   = k_r + 6'd1;
          end else if (!aux_r[0]) begin
            aux_nxt = aux_r >> 1;
          end else if (!y_r[0]) begin
            y_nxt = y_r >> 1;
          end else if (aux_r >= y_r) begin
            aux_nxt = aux_r - y_r;
          end else begin
            y_nxt = y_r - aux_r;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    acc_r  <= acc_nxt;
    aux_r  <= aux_nxt;
    y_r    <= y_nxt;
    cnt_r  <= cnt_nxt;
    k_r    <= k_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.res  = acc_r;
  assign rsp.rem  = aux_r;

endmodule

// ----- src/rational_number_alu.sv -----
// Rational number ALU: takes op and two signed fractions, returns the exact
// reduced result with a positive denominator, or a status code. One item is
// worked at a time; ready is high only while idle. Latency depends on the
// operation and the operand values. Each nonzero operand in use is reduced by
// a binary gcd (one subtract or shift step per cycle) and two bit-serial
// divisions; add and subtract add two gcds, two 128-bit and three 64-bit
// divisions, and every 64x64 multiply is formed on one 32x32 multiplier.
// All of this runs on a single shared unit. A finished result waits in an
// output register, so the next item may be taken before the result is read.
`include "assert_macros.svh"
module rational_number_alu #(
  parameter int WIDTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  rna_in_if.sink    in_ch,
  rna_out_if.source out_ch
);
  import rna_pkg::*;

  localparam logic [63:0] LIM    = 64'd1 << (WIDTH - 1);
  localparam logic [63:0] LIM_M1 = LIM - 64'd1;

  state_t       state_r, state_nxt;
  logic         pend_r, pend_nxt;
  logic         out_valid_r, out_valid_nxt;

  logic [2:0]   op_r, op_nxt;
  logic [63:0]  a_num_r, a_num_nxt, a_den_r, a_den_nxt;
  logic [63:0]  b_num_r, b_num_nxt, b_den_r, b_den_nxt;
  logic         a_neg_r, a_neg_nxt, b_neg_r, b_neg_nxt, neg_r, neg_nxt;
  logic [63:0]  g_r, g_nxt, d1_r, d1_nxt, tmp_r, tmp_nxt;
  logic [127:0] p_r, p_nxt, q_r, q_nxt;

  logic [63:0]  f_num_r, f_num_nxt;
  logic [62:0]  f_den_r, f_den_nxt;
  logic [1:0]   f_st_r, f_st_nxt;
  logic         f_lt_r, f_lt_nxt, f_eq_r, f_eq_nxt;

  logic [63:0]  o_num_r, o_num_nxt;
  logic [62:0]  o_den_r, o_den_nxt;
  logic [1:0]   o_st_r, o_st_nxt;
  logic         o_lt_r, o_lt_nxt, o_eq_r, o_eq_nxt;

  unit_cmd_t    ucmd;
  unit_rsp_t    ursp;

  logic         p_ge_q, p_lt_q, p_eq_q;
  logic [127:0] sum_pq, p_sub_q, q_sub_p;
  logic         ovf;
  logic         out_err, out_flat;

  rna_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (ucmd),
    .rsp   (ursp)
  );

  // Wide compare and add/subtract on the product registers
  assign p_ge_q  = p_r >= q_r;
  assign p_lt_q  = !p_ge_q;
  assign p_eq_q  = p_r == q_r;
  assign sum_pq  = p_r + q_r;
  assign p_sub_q = p_r - q_r;
  assign q_sub_p = q_r - p_r;

  // Range check of the reduced result
  assign ovf = (q_r[127:64] != '0) || (q_r[63:0] == '0) || (q_r[63:0] > LIM_M1) ||
               (p_r[127:64] != '0) ||
               !((p_r[63:0] <= LIM_M1) || (neg_r && (p_r[63:0] == LIM)));

  // Unit command per state
  always_comb begin
    ucmd.start = 1'b0;
    ucmd.kind  = U_GCD;
    ucmd.x     = '0;
    ucmd.y     = '0;
    case (state_r)
      S_NA_G:  begin ucmd.kind = U_GCD;    ucmd.x = {64'd0, a_num_r}; ucmd.y = a_den_r; end
      S_NA_N:  begin ucmd.kind = U_DIV64;  ucmd.x = {64'd0, a_num_r}; ucmd.y = g_r;     end
      S_NA_D:  begin ucmd.kind = U_DIV64;  ucmd.x = {64'd0, a_den_r}; ucmd.y = g_r;     end
      S_NB_G:  begin ucmd.kind = U_GCD;    ucmd.x = {64'd0, b_num_r}; ucmd.y = b_den_r; end
      S_NB_N:  begin ucmd.kind = U_DIV64;  ucmd.x = {64'd0, b_num_r}; ucmd.y = g_r;     end
      S_NB_D:  begin ucmd.kind = U_DIV64;  ucmd.x = {64'd0, b_den_r}; ucmd.y = g_r;     end
      S_AD_G:  begin ucmd.kind = U_GCD;    ucmd.x = {64'd0, a_den_r}; ucmd.y = b_den_r; end
      S_AD_D1: begin ucmd.kind = U_DIV64;  ucmd.x = {64'd0, a_den_r}; ucmd.y = g_r;     end
      S_AD_D2: begin ucmd.kind = U_DIV64;  ucmd.x = {64'd0, b_den_r}; ucmd.y = g_r;     end
      S_AD_P:  begin ucmd.kind = U_MUL;    ucmd.x = {64'd0, a_num_r}; ucmd.y = tmp_r;   end
      S_AD_Q:  begin ucmd.kind = U_MUL;    ucmd.x = {64'd0, b_num_r}; ucmd.y = d1_r;    end
      S_AD_R:  begin ucmd.kind = U_DIV128; ucmd.x = p_r;              ucmd.y = g_r;     end
      S_AD_G2: begin ucmd.kind = U_GCD;    ucmd.x = {64'd0, g_r};     ucmd.y = tmp_r;   end
      S_AD_T2: begin ucmd.kind = U_DIV128; ucmd.x = p_r;              ucmd.y = g_r;     end
      S_AD_D3: begin ucmd.kind = U_DIV64;  ucmd.x = {64'd0, b_den_r}; ucmd.y = g_r;     end
      S_AD_M:  begin ucmd.kind = U_MUL;    ucmd.x = {64'd0, d1_r};    ucmd.y = tmp_r;   end
      S_MU_G1: begin ucmd.kind = U_GCD;    ucmd.x = {64'd0, a_num_r}; ucmd.y = b_den_r; end
      S_MU_G2: begin ucmd.kind = U_GCD;    ucmd.x = {64'd0, b_num_r}; ucmd.y = a_den_r; end
      S_MU_AN: begin ucmd.kind = U_DIV64;  ucmd.x = {64'd0, a_num_r}; ucmd.y = g_r;     end
      S_MU_BD: begin ucmd.kind = U_DIV64;  ucmd.x = {64'd0, b_den_r}; ucmd.y = g_r;     end
      S_MU_BN: begin ucmd.kind = U_DIV64;  ucmd.x = {64'd0, b_num_r}; ucmd.y = d1_r;    end
      S_MU_AD: begin ucmd.kind = U_DIV64;  ucmd.x = {64'd0, a_den_r}; ucmd.y = d1_r;    end
      S_MU_M1: begin ucmd.kind = U_MUL;    ucmd.x = {64'd0, a_num_r}; ucmd.y = b_num_r; end
      S_MU_M2: begin ucmd.kind = U_MUL;    ucmd.x = {64'd0, a_den_r}; ucmd.y = b_den_r; end
      S_CM_L:  begin ucmd.kind = U_MUL;    ucmd.x = {64'd0, a_num_r}; ucmd.y = b_den_r; end
      S_CM_R:  begin ucmd.kind = U_MUL;    ucmd.x = {64'd0, b_num_r}; ucmd.y = a_den_r; end
      default: begin ucmd.kind = U_GCD; end
    endcase
    // NB_G is skipped for a zero b or when b is unused
    if ((state_r == S_NA_G) || (state_r == S_NA_N) || (state_r == S_NA_D) ||
        ((state_r == S_NB_G) && (b_num_r != '0) && (op_r <= OP_CMP)) ||
        (state_r == S_NB_N) || (state_r == S_NB_D) ||
        ((state_r >= S_AD_G) && (state_r <= S_AD_M) && (state_r != S_AD_T)) ||
        ((state_r >= S_MU_G1) && (state_r <= S_CM_R))) begin
      ucmd.start = !pend_r;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    op_nxt   = op_r;
    a_num_nxt = a_num_r; a_den_nxt = a_den_r; b_num_nxt = b_num_r; b_den_nxt = b_den_r;
    a_neg_nxt = a_neg_r; b_neg_nxt = b_neg_r; neg_nxt = neg_r;
    g_nxt = g_r; d1_nxt = d1_r; tmp_nxt = tmp_r; p_nxt = p_r; q_nxt = q_r;
    f_num_nxt = f_num_r; f_den_nxt = f_den_r; f_st_nxt = f_st_r;
    f_lt_nxt = f_lt_r; f_eq_nxt = f_eq_r;
    o_num_nxt = o_num_r; o_den_nxt = o_den_r; o_st_nxt = o_st_r;
    o_lt_nxt = o_lt_r; o_eq_nxt = o_eq_r;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (ucmd.start) pend_nxt = 1'b1;
    if (ursp.done) pend_nxt = 1'b0;

    // default result fields (0/1, OK, not less, not equal) for every path to S_FIN
    if (state_r == S_CHK || state_r == S_DISP || state_r == S_AD_T ||
        state_r == S_CM_C || state_r == S_EMIT) begin
      f_num_nxt = '0;
      f_den_nxt = 63'd1;
      f_st_nxt  = ST_OK;
      f_lt_nxt  = 1'b0;
      f_eq_nxt  = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.op;
          a_num_nxt = in_ch.a_num;
          a_den_nxt = in_ch.a_den;
          b_num_nxt = in_ch.b_num;
          b_den_nxt = in_ch.b_den;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if ((a_den_r == '0) || ((op_r <= OP_CMP) && (b_den_r == '0))) begin
          f_st_nxt  = ST_ZDEN;
          state_nxt = S_FIN;
        end else begin
          // sign to the numerator, magnitudes in place
          a_neg_nxt = a_num_r[63] ^ a_den_r[63];
          a_num_nxt = a_num_r[63] ? -a_num_r : a_num_r;
          a_den_nxt = a_den_r[63] ? -a_den_r : a_den_r;
          b_neg_nxt = b_num_r[63] ^ b_den_r[63];
          b_num_nxt = b_num_r[63] ? -b_num_r : b_num_r;
          b_den_nxt = b_den_r[63] ? -b_den_r : b_den_r;
          if (a_num_r == '0) begin
            a_neg_nxt = 1'b0;
            a_den_nxt = 64'd1;
          end
          if (b_num_r == '0) begin
            b_neg_nxt = 1'b0;
            b_den_nxt = 64'd1;
          end
          state_nxt = (a_num_r == '0) ? S_NB_G : S_NA_G;
        end
      end
      S_NA_G: if (ursp.done) begin g_nxt = ursp.res[63:0]; state_nxt = S_NA_N; end
      S_NA_N: if (ursp.done) begin a_num_nxt = ursp.res[63:0]; state_nxt = S_NA_D; end
      S_NA_D: if (ursp.done) begin a_den_nxt = ursp.res[63:0]; state_nxt = S_NB_G; end
      S_NB_G: begin
        if ((b_num_r == '0) || (op_r > OP_CMP)) begin
          state_nxt = S_DISP;
        end else if (ursp.done) begin
          g_nxt     = ursp.res[63:0];
          state_nxt = S_NB_N;
        end
      end
      S_NB_N: if (ursp.done) begin b_num_nxt = ursp.res[63:0]; state_nxt = S_NB_D; end
      S_NB_D: if (ursp.done) begin b_den_nxt = ursp.res[63:0]; state_nxt = S_DISP; end
      S_DISP: begin
        case (op_r)
          OP_ADD, OP_SUB: begin
            if ((op_r == OP_SUB) && (b_num_r != '0)) b_neg_nxt = !b_neg_r;
            state_nxt = S_AD_G;
          end
          OP_MUL, OP_DIV: begin
            if ((op_r == OP_DIV) && (b_num_r == '0)) begin
              f_st_nxt  = ST_DIVZ;
              state_nxt = S_FIN;
            end else begin
              if (op_r == OP_DIV) begin
                b_num_nxt = b_den_r;
                b_den_nxt = b_num_r;
              end
              neg_nxt = a_neg_r ^ b_neg_r;
              if ((a_num_r == '0) || (b_num_r == '0)) begin
                neg_nxt   = 1'b0;
                p_nxt     = '0;
                q_nxt     = 128'd1;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_MU_G1;
              end
            end
          end
          OP_CMP: state_nxt = S_CM_L;
          default: begin
            neg_nxt   = a_neg_r;
            p_nxt     = {64'd0, a_num_r};
            q_nxt     = {64'd0, a_den_r};
            state_nxt = S_EMIT;
          end
        endcase
      end
      S_AD_G:  if (ursp.done) begin g_nxt = ursp.res[63:0]; state_nxt = S_AD_D1; end
      S_AD_D1: if (ursp.done) begin d1_nxt = ursp.res[63:0]; state_nxt = S_AD_D2; end
      S_AD_D2: if (ursp.done) begin tmp_nxt = ursp.res[63:0]; state_nxt = S_AD_P; end
      S_AD_P:  if (ursp.done) begin p_nxt = ursp.res; state_nxt = S_AD_Q; end
      S_AD_Q:  if (ursp.done) begin q_nxt = ursp.res; state_nxt = S_AD_T; end
      S_AD_T: begin
        // signed sum of the cross products
        if (a_neg_r == b_neg_r) begin
          p_nxt = sum_pq; neg_nxt = a_neg_r;
        end else if (p_ge_q) begin
          p_nxt = p_sub_q; neg_nxt = a_neg_r;
        end else begin
          p_nxt = q_sub_p; neg_nxt = b_neg_r;
        end
        if ((a_neg_r != b_neg_r) && p_eq_q) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_AD_R;
        end
      end
      S_AD_R:  if (ursp.done) begin tmp_nxt = ursp.rem; state_nxt = S_AD_G2; end
      S_AD_G2: if (ursp.done) begin g_nxt = ursp.res[63:0]; state_nxt = S_AD_T2; end
      S_AD_T2: if (ursp.done) begin p_nxt = ursp.res; state_nxt = S_AD_D3; end
      S_AD_D3: if (ursp.done) begin tmp_nxt = ursp.res[63:0]; state_nxt = S_AD_M; end
      S_AD_M:  if (ursp.done) begin q_nxt = ursp.res; state_nxt = S_EMIT; end
      S_MU_G1: if (ursp.done) begin g_nxt = ursp.res[63:0]; state_nxt = S_MU_G2; end
      S_MU_G2: if (ursp.done) begin d1_nxt = ursp.res[63:0]; state_nxt = S_MU_AN; end
      S_MU_AN: if (ursp.done) begin a_num_nxt = ursp.res[63:0]; state_nxt = S_MU_BD; end
      S_MU_BD: if (ursp.done) begin b_den_nxt = ursp.res[63:0]; state_nxt = S_MU_BN; end
      S_MU_BN: if (ursp.done) begin b_num_nxt = ursp.res[63:0]; state_nxt = S_MU_AD; end
      S_MU_AD: if (ursp.done) begin a_den_nxt = ursp.res[63:0]; state_nxt = S_MU_M1; end
      S_MU_M1: if (ursp.done) begin p_nxt = ursp.res; state_nxt = S_MU_M2; end
      S_MU_M2: if (ursp.done) begin q_nxt = ursp.res; state_nxt = S_EMIT; end
      S_CM_L:  if (ursp.done) begin p_nxt = ursp.res; state_nxt = S_CM_R; end
      S_CM_R:  if (ursp.done) begin q_nxt = ursp.res; state_nxt = S_CM_C; end
      S_CM_C: begin
        if (a_neg_r != b_neg_r) begin
          f_lt_nxt = a_neg_r;
        end else if (a_neg_r) begin
          f_lt_nxt = !p_lt_q && !p_eq_q;
          f_eq_nxt = p_eq_q;
        end else begin
          f_lt_nxt = p_lt_q;
          f_eq_nxt = p_eq_q;
        end
        state_nxt = S_FIN;
      end
      S_EMIT: begin
        if (p_r == '0) begin
          f_st_nxt = ST_OK;
        end else if (ovf) begin
          f_st_nxt = ST_OVF;
        end else begin
          f_num_nxt = neg_r ? -p_r[63:0] : p_r[63:0];
          f_den_nxt = q_r[62:0];
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          o_num_nxt     = f_num_r;
          o_den_nxt     = f_den_r;
          o_st_nxt      = f_st_r;
          o_lt_nxt      = f_lt_r;
          o_eq_nxt      = f_eq_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    a_num_r <= a_num_nxt; a_den_r <= a_den_nxt;
    b_num_r <= b_num_nxt; b_den_r <= b_den_nxt;
    a_neg_r <= a_neg_nxt; b_neg_r <= b_neg_nxt; neg_r <= neg_nxt;
    g_r     <= g_nxt; d1_r <= d1_nxt; tmp_r <= tmp_nxt;
    p_r     <= p_nxt; q_r <= q_nxt;
    f_num_r <= f_num_nxt; f_den_r <= f_den_nxt; f_st_r <= f_st_nxt;
    f_lt_r  <= f_lt_nxt; f_eq_r <= f_eq_nxt;
    o_num_r <= o_num_nxt; o_den_r <= o_den_nxt; o_st_r <= o_st_nxt;
    o_lt_r  <= o_lt_nxt; o_eq_r <= o_eq_nxt;
  end

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.res_num = o_num_r;
  assign out_ch.res_den = o_den_r;
  assign out_ch.status  = o_st_r;
  assign out_ch.less    = o_lt_r;
  assign out_ch.equal   = o_eq_r;

  // Error results carry 0/1
  assign out_err  = out_ch.valid && (out_ch.status != ST_OK);
  assign out_flat = (out_ch.res_num == '0) && (out_ch.res_den == 63'd1);

  // Checks
  `RNA_ASSERT(a_unit_idle_on_start, clk, rst_n, ucmd.start |-> !ursp.busy)
  `RNA_ASSERT(a_err_zero_result, clk, rst_n, out_err |-> out_flat)
  `RNA_NEVER(a_less_and_equal, clk, rst_n, out_ch.valid && out_ch.less && out_ch.equal)
  `RNA_NEVER(a_done_unrequested, clk, rst_n, ursp.done && !pend_r)

endmodule
